[src/tfs_pkg.sv]
// ----------------------------------------------------------------------------
// Tightest-fit size search: shared types and constants
// Field widths, the action codes and the words handed from cell to cell.
// ----------------------------------------------------------------------------
package tfs_pkg;

   localparam int SIZE_W  = 16;  // width or height in points
   localparam int INDEX_W = 7;   // entry index on the ports
   localparam int COUNT_W = 8;   // entry_count register
   localparam int SLACK_W = 17;  // sum of two 16-bit differences

   typedef enum logic {
      ACT_WRITE = 1'b0,
      ACT_QUERY = 1'b1
   } tfs_action_type;

   // Table write broadcast to every cell.
   typedef struct packed {
      logic               en;
      logic [INDEX_W-1:0] index;
      logic [SIZE_W-1:0]  width;
      logic [SIZE_W-1:0]  height;
   } tfs_write_type;

   // Query word that walks down the chain, one cell per cycle while the chain advances.
   typedef struct packed {
      logic               valid;
      logic               live;    // query is not the zero size
      logic [SIZE_W-1:0]  qw;
      logic [SIZE_W-1:0]  qh;
      logic               have;    // some earlier cell fits
      logic [SLACK_W-1:0] slack;   // slack of the best fit so far
   } tfs_token_type;

endpackage

[src/tfs_req_if.sv]
// ----------------------------------------------------------------------------
// Tightest-fit size search: request channel
// Valid/ready channel that carries table writes and queries.
// ----------------------------------------------------------------------------
interface tfs_req_if;

   logic                       valid;
   logic                       ready;
   logic                       action;
   logic [tfs_pkg::INDEX_W-1:0] entry_index;
   logic [tfs_pkg::SIZE_W-1:0]  size_width;
   logic [tfs_pkg::SIZE_W-1:0]  size_height;

   modport source (output valid, action, entry_index, size_width, size_height,
                   input ready);
   modport sink   (input valid, action, entry_index, size_width, size_height,
                   output ready);

endinterface

[src/tfs_rsp_if.sv]
// ----------------------------------------------------------------------------
// Tightest-fit size search: response channel
// Valid/ready channel that carries one search result per query.
// ----------------------------------------------------------------------------
interface tfs_rsp_if;

   logic                        valid;
   logic                        ready;
   logic                        found;
   logic [tfs_pkg::INDEX_W-1:0] best_index;

   modport source (output valid, found, best_index, input ready);
   modport sink   (input valid, found, best_index, output ready);

endinterface

[src/tfs_cell.sv]
// ----------------------------------------------------------------------------
// Tightest-fit size search: one table cell
// Holds one table entry and updates the passing query word with it.
// ----------------------------------------------------------------------------
module tfs_cell #(
   parameter int CELL_INDEX = 0,
   parameter int IDX_W      = 7
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  tfs_pkg::tfs_write_type       wr,
   input  logic [tfs_pkg::COUNT_W-1:0]  count,
   input  tfs_pkg::tfs_token_type       tok_in,
   input  logic [IDX_W-1:0]             best_in,
   output tfs_pkg::tfs_token_type       tok_out,
   output logic [IDX_W-1:0]             best_out
);

   localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(CELL_INDEX);

   logic [tfs_pkg::SIZE_W-1:0]  ew_ff;
   logic [tfs_pkg::SIZE_W-1:0]  eh_ff;
   tfs_pkg::tfs_token_type      tok_ff;
   tfs_pkg::tfs_token_type      tok_in_w;
   logic [IDX_W-1:0]            best_ff;
   logic [IDX_W-1:0]            best_in_w;
   logic                        in_scope;
   logic                        fits;
   logic                        take;
   logic [tfs_pkg::SLACK_W-1:0] slack;

   always_ff @(posedge clock) begin
      if (wr.en && ({25'b0, wr.index} == 32'(CELL_INDEX))) begin
         ew_ff <= wr.width;
         eh_ff <= wr.height;
      end
   end

   always_comb begin
      in_scope = 32'(CELL_INDEX) < {24'b0, count};
      fits     = tok_in.valid && tok_in.live && in_scope &&
                 (tok_in.qw <= ew_ff) && (tok_in.qh <= eh_ff);
      slack    = {1'b0, ew_ff - tok_in.qw} + {1'b0, eh_ff - tok_in.qh};
      // Strict compare keeps the lower index on a tie.
      take     = fits && (!tok_in.have || (slack < tok_in.slack));

      tok_in_w  = tok_in;
      best_in_w = best_in;
      if (take) begin
         tok_in_w.have  = 1'b1;
         tok_in_w.slack = slack;
         best_in_w      = MY_INDEX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff  <= tok_in_w;
         best_ff <= best_in_w;
      end
   end

   assign tok_out  = tok_ff;
   assign best_out = best_ff;

endmodule

[src/tightest_fit_size_search.sv]
// ----------------------------------------------------------------------------
// Tightest-fit size search
// Table of width/height pairs searched for the entry with the least slack.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries words of two kinds. A write (action 0) loads entry
//   entry_index with size_width/size_height and gives no response; indexes
//   at or above TABLE_DEPTH are dropped. A query (action 1) searches the
//   entries below both csr entry_count and TABLE_DEPTH and gives one word on
//   rsp_chan: found and the index of the tightest fit, lowest index on a tie.
//   Each entry must be written before a query scans it.
//   The table is a row of TABLE_DEPTH cells; the query word moves one cell
//   per cycle while the chain advances, through each cell's register in
//   turn and then into the response register. No new word is taken while a
//   query is in the chain; writes can be taken back to back while idle.
//   The response sits in an output register; a new query may run while it
//   waits. If the receiver stalls, the chain freezes once a finished query
//   reaches its end. csr_we writes entry_count; do so only while idle.
//   Reset (synchronous) empties the chain and the response register and
//   clears entry_count; table contents stay undefined until written.
// ----------------------------------------------------------------------------
module tightest_fit_size_search #(
   parameter int TABLE_DEPTH = 128
) (
   input  logic                        clock,
   input  logic                        reset,
   tfs_req_if.sink                     req_chan,
   tfs_rsp_if.source                   rsp_chan,
   input  logic                        csr_we,
   input  logic [tfs_pkg::COUNT_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic [tfs_pkg::COUNT_W-1:0]  count_ff;
   logic                         busy_ff;
   logic                         busy_in;
   logic                         rsp_valid_ff;
   logic                         found_ff;
   logic [tfs_pkg::INDEX_W-1:0]  best_ff;
   logic                         req_acc;
   logic                         query_acc;
   logic                         advance;
   logic                         tail_load;
   tfs_pkg::tfs_write_type       wr;
   tfs_pkg::tfs_token_type       head_tok;
   tfs_pkg::tfs_token_type       tok   [TABLE_DEPTH];
   logic [IDX_W-1:0]             best  [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]       tok_valid;
   logic [IDX_W+tfs_pkg::INDEX_W-1:0] tail_wide;

   assign req_acc   = req_chan.valid && req_chan.ready;
   assign query_acc = req_acc && (req_chan.action == tfs_pkg::ACT_QUERY);

   always_comb begin
      wr.en     = req_acc && (req_chan.action == tfs_pkg::ACT_WRITE);
      wr.index  = req_chan.entry_index;
      wr.width  = req_chan.size_width;
      wr.height = req_chan.size_height;

      head_tok.valid = query_acc;
      head_tok.live  = (req_chan.size_width != '0) || (req_chan.size_height != '0);
      head_tok.qw    = req_chan.size_width;
      head_tok.qh    = req_chan.size_height;
      head_tok.have  = 1'b0;
      head_tok.slack = '0;
   end

   // The chain only stops when a finished query cannot leave it.
   assign advance   = !tok[TABLE_DEPTH-1].valid || !rsp_valid_ff || rsp_chan.ready;
   assign tail_load = tok[TABLE_DEPTH-1].valid && advance;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         tfs_cell #(
            .CELL_INDEX (i),
            .IDX_W      (IDX_W)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .advance  (advance),
            .wr       (wr),
            .count    (count_ff),
            .tok_in   (head_tok),
            .best_in  ({IDX_W{1'b0}}),
            .tok_out  (tok[i]),
            .best_out (best[i])
         );
      end else begin : g_body
         tfs_cell #(
            .CELL_INDEX (i),
            .IDX_W      (IDX_W)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .advance  (advance),
            .wr       (wr),
            .count    (count_ff),
            .tok_in   (tok[i-1]),
            .best_in  (best[i-1]),
            .tok_out  (tok[i]),
            .best_out (best[i])
         );
      end
      assign tok_valid[i] = tok[i].valid;
   end

   assign tail_wide = {{tfs_pkg::INDEX_W{1'b0}}, best[TABLE_DEPTH-1]};

   always_comb begin
      busy_in = busy_ff;
      if (query_acc) begin
         busy_in = 1'b1;
      end else if (tail_load) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
         busy_ff <= busy_in;
         if (tail_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tail_load) begin
         found_ff <= tok[TABLE_DEPTH-1].have;
         best_ff  <= tok[TABLE_DEPTH-1].have ? tail_wide[tfs_pkg::INDEX_W-1:0] : '0;
      end
   end

   assign req_chan.ready      = !busy_ff;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.found      = found_ff;
   assign rsp_chan.best_index = best_ff;

`ifndef SYNTHESIS
   a_one_query: assert property (@(posedge clock) disable iff (reset)
      $countones(tok_valid) <= 1)
      else $error("more than one query word in the chain");

   a_word_needs_busy: assert property (@(posedge clock) disable iff (reset)
      (tok_valid != '0) |-> busy_ff)
      else $error("query word in the chain while not busy");

   a_query_sets_busy: assert property (@(posedge clock) disable iff (reset)
      query_acc |=> (busy_ff && tok[0].valid))
      else $error("accepted query did not enter the chain");

   a_not_found_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !found_ff) |-> (best_ff == '0))
      else $error("not-found response with nonzero index");
`endif

endmodule

[dv/tightest_fit_size_search_tb.sv]
// ----------------------------------------------------------------------------
// Tightest-fit size search testbench
// Loads the size table, sweeps entry_count across its range and runs
// best-fit queries under random sender and receiver stalls. Every response
// word is checked against a typed expected value or a search model in the bench.
// ----------------------------------------------------------------------------
module tightest_fit_size_search_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH         = 128;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = DEPTH + 8;
   localparam int RANDOM_ITEMS  = 1450;

   typedef struct packed {
      logic                        found;
      logic [tfs_pkg::INDEX_W-1:0] best_index;
   } fit_type;

   typedef struct packed {
      logic [tfs_pkg::COUNT_W-1:0] count;
      tfs_pkg::tfs_action_type     action;
      logic [tfs_pkg::INDEX_W-1:0] index;
      logic [tfs_pkg::SIZE_W-1:0]  width;
      logic [tfs_pkg::SIZE_W-1:0]  height;
      logic                        typed;
      fit_type                     fit;
   } probe_type;

   // Directed words. The typed column marks rows whose response is written
   // out here; all other queries are checked against the search model.
   localparam probe_type DIRECTED [21] = '{
      '{8'd0, tfs_pkg::ACT_QUERY, 7'd0,   16'd5,    16'd5,    1'b1, '{1'b0, 7'd0}},
      '{8'd0, tfs_pkg::ACT_WRITE, 7'd0,   16'hFFFF, 16'hFFFF, 1'b0, '{1'b0, 7'd0}},
      '{8'd0, tfs_pkg::ACT_WRITE, 7'd1,   16'd10,   16'd20,   1'b0, '{1'b0, 7'd0}},
      '{8'd0, tfs_pkg::ACT_WRITE, 7'd2,   16'd10,   16'd20,   1'b0, '{1'b0, 7'd0}},
      '{8'd0, tfs_pkg::ACT_WRITE, 7'd3,   16'd0,    16'd0,    1'b0, '{1'b0, 7'd0}},
      '{8'd0, tfs_pkg::ACT_WRITE, 7'd127, 16'd100,  16'd100,  1'b0, '{1'b0, 7'd0}},
      '{8'd4, tfs_pkg::ACT_QUERY, 7'd0,   16'd0,    16'd0,    1'b1, '{1'b0, 7'd0}},
      '{8'd4, tfs_pkg::ACT_QUERY, 7'd127, 16'd10,   16'd20,   1'b1, '{1'b1, 7'd1}},
      '{8'd4, tfs_pkg::ACT_QUERY, 7'd0,   16'd9,    16'd20,   1'b0, '{1'b0, 7'd0}},
      '{8'd4, tfs_pkg::ACT_QUERY, 7'd0,   16'hFFFF, 16'hFFFF, 1'b1, '{1'b1, 7'd0}},
      '{8'd4, tfs_pkg::ACT_QUERY, 7'd0,   16'd0,    16'd1,    1'b0, '{1'b0, 7'd0}},
      '{8'd4, tfs_pkg::ACT_QUERY, 7'd0,   16'd1,    16'd0,    1'b0, '{1'b0, 7'd0}},
      '{8'd4, tfs_pkg::ACT_QUERY, 7'd0,   16'hFFFF, 16'd0,    1'b0, '{1'b0, 7'd0}},
      '{8'd1, tfs_pkg::ACT_QUERY, 7'd0,   16'd11,   16'd20,   1'b1, '{1'b1, 7'd0}},
      '{8'd1, tfs_pkg::ACT_WRITE, 7'd0,   16'd5,    16'd5,    1'b0, '{1'b0, 7'd0}},
      '{8'd1, tfs_pkg::ACT_QUERY, 7'd0,   16'd6,    16'd1,    1'b1, '{1'b0, 7'd0}},
      '{8'd1, tfs_pkg::ACT_QUERY, 7'd0,   16'd5,    16'd5,    1'b1, '{1'b1, 7'd0}},
      '{8'd4, tfs_pkg::ACT_QUERY, 7'd0,   16'd5,    16'd5,    1'b0, '{1'b0, 7'd0}},
      '{8'd4, tfs_pkg::ACT_WRITE, 7'd3,   16'hFFFF, 16'hFFFF, 1'b0, '{1'b0, 7'd0}},
      '{8'd4, tfs_pkg::ACT_QUERY, 7'd0,   16'd6,    16'd6,    1'b0, '{1'b0, 7'd0}},
      '{8'd4, tfs_pkg::ACT_QUERY, 7'd127, 16'd0,    16'd0,    1'b1, '{1'b0, 7'd0}}
   };

   logic                        clock;
   logic                        reset;
   logic                        csr_we;
   logic [tfs_pkg::COUNT_W-1:0] csr_wdata;

   tfs_req_if req_chan();
   tfs_rsp_if rsp_chan();

   tightest_fit_size_search #(
      .TABLE_DEPTH(DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   // Bench copy of the table and the register.
   logic [tfs_pkg::SIZE_W-1:0]  size_w [DEPTH];
   logic [tfs_pkg::SIZE_W-1:0]  size_h [DEPTH];
   logic [tfs_pkg::COUNT_W-1:0] scan_count;

   fit_type pending_fits [$];
   bit      calm;
   bit      run_done;
   int      errors;
   int      queries;
   int      writes;
   int      hits;
   int      phases;
   int      idle_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic fit_type tightest_fit(logic [tfs_pkg::SIZE_W-1:0] qw,
                                            logic [tfs_pkg::SIZE_W-1:0] qh);
      fit_type                     r;
      int                          lim;
      logic [tfs_pkg::SLACK_W-1:0] best_slack;
      logic [tfs_pkg::SLACK_W-1:0] slack;
      r = '0;
      best_slack = '0;
      lim = (scan_count > DEPTH) ? DEPTH : int'(scan_count);
      if (qw != 0 || qh != 0) begin
         for (int i = 0; i < lim; i++) begin
            if (qw <= size_w[i] && qh <= size_h[i]) begin
               slack = {1'b0, size_w[i] - qw} + {1'b0, size_h[i] - qh};
               // Strict compare keeps the lowest index on a tie.
               if (!r.found || slack < best_slack) begin
                  r.found = 1'b1;
                  r.best_index = tfs_pkg::INDEX_W'(i);
                  best_slack = slack;
               end
            end
         end
      end
      return r;
   endfunction

   function automatic logic [tfs_pkg::SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 5))
         0: return tfs_pkg::SIZE_W'($urandom);
         1: return tfs_pkg::SIZE_W'($urandom_range(0, 15));
         2: return tfs_pkg::SIZE_W'($urandom_range(16'hFFF0, 16'hFFFF));
         3: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: return tfs_pkg::SIZE_W'($urandom_range(16, 300));
      endcase
   endfunction

   // Presents one word and holds it until it is taken. The valid line is
   // only lowered when a gap is wanted, so it never toggles within one step.
   task automatic drive_word(probe_type p, int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.action      <= p.action;
      req_chan.entry_index <= p.index;
      req_chan.size_width  <= p.width;
      req_chan.size_height <= p.height;
      do @(posedge clock); while (!req_chan.ready);
      if (p.action == tfs_pkg::ACT_WRITE) begin
         size_w[p.index] = p.width;
         size_h[p.index] = p.height;
         writes++;
      end else begin
         pending_fits.push_back(p.typed ? p.fit : tightest_fit(p.width, p.height));
         queries++;
      end
   endtask

   task automatic req_idle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_fits.size() != 0) @(posedge clock);
   endtask

   task automatic set_count(logic [tfs_pkg::COUNT_W-1:0] value);
      req_idle();
      wait_drained();
      repeat (8) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      scan_count = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Receiver: random stall before each response word, none in calm phases.
   initial begin : rsp_side
      int unsigned stall;
      rsp_chan.ready = 1'b0;
      forever begin
         stall = calm ? 0 : $urandom_range(0, 3);
         @(negedge clock);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   always @(posedge clock) begin : rsp_check
      fit_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (rsp_chan.found) hits++;
         if (pending_fits.size() == 0) begin
            $error("response word with no query waiting: found %0b best_index %0d",
                   rsp_chan.found, rsp_chan.best_index);
            errors++;
         end else begin
            want = pending_fits.pop_front();
            if (rsp_chan.found !== want.found) begin
               $error("found: expected %0b, got %0b", want.found, rsp_chan.found);
               errors++;
            end
            if (rsp_chan.best_index !== want.best_index) begin
               $error("best_index: expected %0d, got %0d",
                      want.best_index, rsp_chan.best_index);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!run_done) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
             || csr_we)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("tightest_fit_size_search_tb: errors");
            $finish;
         end
      end
   end

   initial begin : stimulus
      probe_type                   p;
      int                          rand_items;
      int                          len;
      int                          hold_at;
      int                          lim;
      logic [tfs_pkg::COUNT_W-1:0] cnt;
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_wdata            = '0;
      req_chan.valid       = 1'b0;
      req_chan.action      = tfs_pkg::ACT_WRITE;
      req_chan.entry_index = '0;
      req_chan.size_width  = '0;
      req_chan.size_height = '0;
      scan_count           = '0;
      calm                 = 1'b0;
      run_done             = 1'b0;
      queries              = 0;
      writes               = 0;
      phases               = 0;
      rand_items           = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < $size(DIRECTED); r++) begin
         if (DIRECTED[r].count != scan_count) set_count(DIRECTED[r].count);
         drive_word(DIRECTED[r], $urandom_range(0, 3));
      end

      // Fill the whole table so that any count can be scanned legally.
      p = '0;
      p.action = tfs_pkg::ACT_WRITE;
      for (int i = 0; i < DEPTH; i++) begin
         p.index  = tfs_pkg::INDEX_W'(i);
         p.width  = pick_size();
         p.height = pick_size();
         drive_word(p, $urandom_range(0, 3));
      end

      while (rand_items < RANDOM_ITEMS) begin
         case (phases)
            0: cnt = 8'd128;
            1: cnt = 8'd255;
            2: cnt = 8'd0;
            3: cnt = 8'd1;
            default: begin
               case ($urandom_range(0, 4))
                  0: cnt = tfs_pkg::COUNT_W'($urandom_range(129, 254));
                  1: cnt = tfs_pkg::COUNT_W'($urandom_range(1, 8));
                  2: cnt = 8'd128;
                  default: cnt = tfs_pkg::COUNT_W'($urandom_range(2, 127));
               endcase
            end
         endcase
         set_count(cnt);
         calm = (phases % 3 == 2);
         lim = (cnt > DEPTH) ? DEPTH : int'(cnt);
         len = $urandom_range(100, 180);
         hold_at = $urandom_range(10, len - 10);
         for (int k = 0; k < len && rand_items < RANDOM_ITEMS; k++) begin
            // Once per phase the sender waits for the block to drain.
            if (k == hold_at) begin
               req_idle();
               wait_drained();
            end
            p = '0;
            p.action = ($urandom_range(0, 9) < 4) ? tfs_pkg::ACT_WRITE : tfs_pkg::ACT_QUERY;
            if (lim > 0 && $urandom_range(0, 1))
               p.index = tfs_pkg::INDEX_W'($urandom_range(0, lim - 1));
            else
               p.index = tfs_pkg::INDEX_W'($urandom_range(0, DEPTH - 1));
            if (p.action == tfs_pkg::ACT_QUERY && $urandom_range(0, 19) == 0) begin
               p.width  = '0;
               p.height = '0;
            end else begin
               p.width  = pick_size();
               p.height = pick_size();
            end
            drive_word(p, calm ? 0 : $urandom_range(0, 3));
            rand_items++;
         end
         phases++;
      end

      calm = 1'b0;
      req_idle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      run_done = 1'b1;
      $display("covered %0d table writes and %0d queries (%0d with a fit) over %0d",
               writes, queries, hits, phases);
      $display("random entry_count settings, including 0, 1, 128 and 255");
      if (errors == 0)
         $display("tightest_fit_size_search_tb: clean");
      else
         $display("tightest_fit_size_search_tb: errors");
      $finish;
   end

endmodule
